// ===== design/vgmcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// vgmcsp_pkg
// Shared types and constants for the VGM command stream parser.
// ----------------------------------------------------------------------------
package vgmcsp_pkg;

	localparam int BYTE_W      = 8;
	localparam int WAIT_W      = 16;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [BYTE_W-1:0] OP_WAIT_LONG = 8'd97;
	localparam logic [BYTE_W-1:0] OP_WAIT_NTSC = 8'd98;
	localparam logic [BYTE_W-1:0] OP_WAIT_PAL  = 8'd99;
	localparam logic [BYTE_W-1:0] OP_END       = 8'd102;
	localparam logic [BYTE_W-1:0] OP_WRITE     = 8'd160;
	localparam logic [3:0]        OP_SHORT_HI  = 4'h7;

	localparam logic [WAIT_W-1:0] WAIT_NTSC    = 16'd735;
	localparam logic [WAIT_W-1:0] WAIT_PAL     = 16'd882;

	localparam logic [BYTE_W-1:0] MUTE_ADDR    = 8'd7;
	localparam logic [BYTE_W-1:0] MUTE_VALUE   = 8'b11111111;

	typedef enum logic [1:0] {
		EV_WRITE   = 2'd0,
		EV_WAIT    = 2'd1,
		EV_END     = 2'd2,
		EV_UNKNOWN = 2'd3
	} event_kind_t;

	typedef struct packed {
		event_kind_t         kind;
		logic [BYTE_W-1:0]   reg_address;
		logic [BYTE_W-1:0]   reg_value;
		logic [WAIT_W-1:0]   wait_samples;
		logic                run_last;
	} event_t;

	// up to two events from one byte, already compacted into slot a first
	typedef struct packed {
		logic [1:0] count;
		event_t     ev_a;
		event_t     ev_b;
	} push_t;

endpackage

// ===== design/vgmcsp_parser.sv =====
// ----------------------------------------------------------------------------
// vgmcsp_parser
// Parse phase machine: decodes one stream byte per beat into up to two events.
// ----------------------------------------------------------------------------
module vgmcsp_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [vgmcsp_pkg::BYTE_W-1:0]     stream_byte,
	input  logic                              final_byte,
	output vgmcsp_pkg::push_t                 push
);
	import vgmcsp_pkg::*;

	typedef enum logic [1:0] {
		PH_OPCODE = 2'd0,
		PH_ARG1   = 2'd1,
		PH_ARG2   = 2'd2
	} phase_t;

	phase_t            phase_q, phase_d;
	logic              is_write_q, is_write_d;
	logic [BYTE_W-1:0] first_arg_q, first_arg_d;

	logic   cmd_valid;
	event_t cmd_ev;
	event_t mute_ev;

	always_comb begin
		phase_d     = phase_q;
		is_write_d  = is_write_q;
		first_arg_d = first_arg_q;
		cmd_valid   = 1'b0;
		cmd_ev      = '0;

		case (phase_q)
			PH_ARG1: begin
				first_arg_d = stream_byte;
				phase_d     = PH_ARG2;
			end
			PH_ARG2: begin
				cmd_valid = 1'b1;
				if (is_write_q) begin
					cmd_ev.kind        = EV_WRITE;
					cmd_ev.reg_address = first_arg_q;
					cmd_ev.reg_value   = stream_byte;
				end else begin
					cmd_ev.kind         = EV_WAIT;
					cmd_ev.wait_samples = {stream_byte, first_arg_q};
				end
				phase_d = PH_OPCODE;
			end
			default: begin
				phase_d = PH_OPCODE;
				case (stream_byte)
					OP_WAIT_LONG: begin
						is_write_d = 1'b0;
						phase_d    = PH_ARG1;
					end
					OP_WRITE: begin
						is_write_d = 1'b1;
						phase_d    = PH_ARG1;
					end
					OP_WAIT_NTSC: begin
						cmd_valid           = 1'b1;
						cmd_ev.kind         = EV_WAIT;
						cmd_ev.wait_samples = WAIT_NTSC;
					end
					OP_WAIT_PAL: begin
						cmd_valid           = 1'b1;
						cmd_ev.kind         = EV_WAIT;
						cmd_ev.wait_samples = WAIT_PAL;
					end
					OP_END: begin
						cmd_valid   = 1'b1;
						cmd_ev.kind = EV_END;
					end
					default: begin
						cmd_valid = 1'b1;
						if (stream_byte[7:4] == OP_SHORT_HI) begin
							cmd_ev.kind         = EV_WAIT;
							cmd_ev.wait_samples = {12'd0, stream_byte[3:0]} + 16'd1;
						end else begin
							cmd_ev.kind      = EV_UNKNOWN;
							cmd_ev.reg_value = stream_byte;
						end
					end
				endcase
			end
		endcase

		cmd_ev.run_last = ~final_byte;

		if (final_byte) begin
			phase_d     = PH_OPCODE;
			is_write_d  = 1'b0;
			first_arg_d = '0;
		end
	end

	always_comb begin
		mute_ev             = '0;
		mute_ev.kind        = EV_WRITE;
		mute_ev.reg_address = MUTE_ADDR;
		mute_ev.reg_value   = MUTE_VALUE;
		mute_ev.run_last    = 1'b1;

		push = '0;
		if (accept) begin
			push.count = 2'({1'b0, cmd_valid} + {1'b0, final_byte});
			push.ev_a  = cmd_valid ? cmd_ev : mute_ev;
			push.ev_b  = mute_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OPCODE;
			is_write_q  <= 1'b0;
			first_arg_q <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			is_write_q  <= is_write_d;
			first_arg_q <= first_arg_d;
		end
	end

endmodule

// ===== design/vgmcsp_event_fifo.sv =====
// ----------------------------------------------------------------------------
// vgmcsp_event_fifo
// Small result queue: takes up to two events a cycle, gives one per beat.
// ----------------------------------------------------------------------------
module vgmcsp_event_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  vgmcsp_pkg::push_t   push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output vgmcsp_pkg::event_t  out_event
);
	import vgmcsp_pkg::*;

	event_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	// room for a full two-event push
	assign room      = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign out_event = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wr_ptr_q] <= push.ev_a;
		if (push.count == 2'd2)
			mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push.ev_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			count_q <= count_q + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
		end
	end

endmodule

// ===== design/vgm_command_stream_parser.sv =====
// ----------------------------------------------------------------------------
// vgm_command_stream_parser
// An event is registered in the event queue when its byte is taken; m_tvalid offers it from there.
// Throughput: one byte per cycle; a final byte that also completes a command
// gives two beats, the queue takes the extra beat, and s_tready drops only
// while more than two events wait. The four-entry event queue sets the slack.
// Reset clears the parse phase, pending command and the event queue.
// ----------------------------------------------------------------------------
module vgm_command_stream_parser (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] stream_byte
	input  logic        s_tlast,   // final_byte

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] reg_address, [15:8] reg_value, [31:16] wait_samples
	output logic [1:0]  m_tuser,   // [1:0] event_kind
	output logic        m_tlast    // run_last
);
	import vgmcsp_pkg::*;

	push_t  push;
	logic   room;
	logic   accept;
	event_t out_event;

	assign s_tready = room;
	assign accept   = s_tvalid && room;

	vgmcsp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.stream_byte (s_tdata),
		.final_byte  (s_tlast),
		.push        (push)
	);

	vgmcsp_event_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_event (out_event)
	);

	assign m_tdata = {out_event.wait_samples, out_event.reg_value, out_event.reg_address};
	assign m_tuser = out_event.kind;
	assign m_tlast = out_event.run_last;

endmodule
